[design/cwip_pkg.sv]
// Shared types, constants and the microcode program of the index permutation unit.
`default_nettype none

package cwip_pkg;

    // Round constants
    localparam logic [63:0] ROUND_OFFSET = 64'h2545f4914f6cdd1d;
    localparam logic [63:0] ROUND_MUL_A  = 64'h9e3779b97f4a7c15;
    localparam logic [63:0] ROUND_MUL_B  = 64'hbf58476d1ce4e5b9;
    localparam logic [63:0] ROUND_MUL_C  = 64'h94d049bb133111eb;

    // Program geometry
    localparam int STEP_W = 5;
    localparam logic [STEP_W-1:0] ROUND_START = 5'd1;
    localparam logic [STEP_W-1:0] STEP_INC    = 5'd1;

    // Datapath operations, one per control word
    typedef enum logic [3:0] {
        OP_NOP,
        OP_ADD,
        OP_MUL0,
        OP_MUL1,
        OP_MUL2,
        OP_MUL3,
        OP_XS1,
        OP_XS2
    } op_t;

    // Multiplier constant select
    typedef enum logic [1:0] {
        K_A,
        K_B,
        K_C
    } ksel_t;

    // Sequencing of a control word
    typedef enum logic [1:0] {
        BR_NEXT,
        BR_REJECT,
        BR_LOOP
    } branch_t;

    typedef enum logic {
        SEQ_IDLE,
        SEQ_RUN
    } seq_state_t;

    typedef struct packed {
        op_t               op;
        ksel_t             ksel;
        branch_t           br;
        logic [STEP_W-1:0] target;
    } ucode_t;

    // Sequencer to datapath
    typedef struct packed {
        op_t   op;
        ksel_t ksel;
        logic  load_in;
        logic  load_out;
        logic  out_rej;
    } ctrl_t;

    // Back to the sequencer
    typedef struct packed {
        logic v_ge_size;
        logic cfg_busy;
    } status_t;

    // Derived configuration
    typedef struct packed {
        logic [63:0] size;
        logic [63:0] mask;
        logic [5:0]  first_shift;
        logic [5:0]  second_shift;
    } cfg_t;

    // Control store: input check, then one round of 16 steps ending in the walk test
    function automatic ucode_t ucode_word(input logic [STEP_W-1:0] step);
        ucode_t w;
        w = '{op: OP_NOP, ksel: K_A, br: BR_NEXT, target: ROUND_START};
        unique case (step)
            5'd0:  w.br = BR_REJECT;
            5'd1:  w.op = OP_ADD;
            5'd2:  w.op = OP_MUL0;
            5'd3:  w.op = OP_MUL1;
            5'd4:  w.op = OP_MUL2;
            5'd5:  w.op = OP_MUL3;
            5'd6:  w.op = OP_XS1;
            5'd7:  begin w.op = OP_MUL0; w.ksel = K_B; end
            5'd8:  begin w.op = OP_MUL1; w.ksel = K_B; end
            5'd9:  begin w.op = OP_MUL2; w.ksel = K_B; end
            5'd10: begin w.op = OP_MUL3; w.ksel = K_B; end
            5'd11: w.op = OP_XS2;
            5'd12: begin w.op = OP_MUL0; w.ksel = K_C; end
            5'd13: begin w.op = OP_MUL1; w.ksel = K_C; end
            5'd14: begin w.op = OP_MUL2; w.ksel = K_C; end
            5'd15: begin w.op = OP_MUL3; w.ksel = K_C; end
            5'd16: w.br = BR_LOOP;
            default: w.br = BR_LOOP;
        endcase
        return w;
    endfunction

    // Selected multiplier constant
    function automatic logic [63:0] mul_const(input ksel_t ksel);
        logic [63:0] k;
        case (ksel)
            K_A:     k = ROUND_MUL_A;
            K_B:     k = ROUND_MUL_B;
            K_C:     k = ROUND_MUL_C;
            default: k = ROUND_MUL_A;
        endcase
        return k;
    endfunction

endpackage

`default_nettype wire

[design/cwip_cfg_unit.sv]
// Domain size register and the serial derivation of mask and shift amounts.
`default_nettype none

module cwip_cfg_unit (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           domain_size_we,
    input  wire logic [63:0]    domain_size,
    output cwip_pkg::cfg_t      cfg,
    output logic                busy
);

    logic [63:0] size_reg, size_next;
    logic [63:0] mask_reg, mask_next;
    logic [6:0]  bits_reg, bits_next;
    logic [5:0]  third_reg, third_next;
    logic [1:0]  rem3_reg, rem3_next;
    logic        busy_reg, busy_next;
    logic        grow;

    // Covering range still below the size: (mask + 1) < size
    assign grow = ({1'b0, mask_reg} + 65'd1) < {1'b0, size_reg};

    // One bit of covering width per cycle, tracking bits / 3 on the way
    always_comb
    begin
        size_next  = size_reg;
        mask_next  = mask_reg;
        bits_next  = bits_reg;
        third_next = third_reg;
        rem3_next  = rem3_reg;
        busy_next  = busy_reg;
        if (domain_size_we)
        begin
            size_next  = domain_size;
            mask_next  = '0;
            bits_next  = '0;
            third_next = '0;
            rem3_next  = '0;
            busy_next  = 1'b1;
        end
        else if (busy_reg)
        begin
            if (grow)
            begin
                mask_next = {mask_reg[62:0], 1'b1};
                bits_next = bits_reg + 7'd1;
                if (rem3_reg == 2'd2)
                begin
                    rem3_next  = 2'd0;
                    third_next = third_reg + 6'd1;
                end
                else
                begin
                    rem3_next = rem3_reg + 2'd1;
                end
            end
            else
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_reg  <= 64'd1;
            mask_reg  <= '0;
            bits_reg  <= '0;
            third_reg <= '0;
            rem3_reg  <= '0;
            busy_reg  <= 1'b0;
        end
        else
        begin
            size_reg  <= size_next;
            mask_reg  <= mask_next;
            bits_reg  <= bits_next;
            third_reg <= third_next;
            rem3_reg  <= rem3_next;
            busy_reg  <= busy_next;
        end
    end

    // Shift amounts, each at least one
    always_comb
    begin
        cfg.size         = size_reg;
        cfg.mask         = mask_reg;
        cfg.first_shift  = (bits_reg[6:1] == 6'd0) ? 6'd1 : bits_reg[6:1];
        cfg.second_shift = (third_reg == 6'd0) ? 6'd1 : third_reg;
    end

    assign busy = busy_reg;

endmodule

`default_nettype wire

[design/cwip_datapath.sv]
// Walk value register, shared 32x32 multiplier, xor-shift and result registers.
`default_nettype none

module cwip_datapath (
    input  wire logic           clk,
    input  wire cwip_pkg::ctrl_t ctrl,
    input  wire cwip_pkg::cfg_t  cfg,
    input  wire logic [63:0]    index,
    output logic                v_ge_size,
    output logic [63:0]         permuted_index,
    output logic                rejected
);

    logic [63:0] v_reg, v_next;
    logic [63:0] acc_reg, acc_next;
    logic [63:0] prod_reg;
    logic [63:0] perm_reg;
    logic        rej_reg;
    logic [63:0] k;
    logic [31:0] mul_a, mul_b;

    assign k = cwip_pkg::mul_const(ctrl.ksel);

    // Partial product operands: lo*lo, lo*hi, hi*lo
    assign mul_a = (ctrl.op == cwip_pkg::OP_MUL2) ? v_reg[63:32] : v_reg[31:0];
    assign mul_b = (ctrl.op == cwip_pkg::OP_MUL1) ? k[63:32] : k[31:0];

    always_ff @(posedge clk)
    begin
        prod_reg <= 64'(mul_a) * 64'(mul_b);
    end

    // Round step selected by the control word
    always_comb
    begin
        v_next   = v_reg;
        acc_next = acc_reg;
        case (ctrl.op)
            cwip_pkg::OP_ADD:  v_next = (v_reg + cwip_pkg::ROUND_OFFSET) & cfg.mask;
            cwip_pkg::OP_MUL1: acc_next = prod_reg;
            cwip_pkg::OP_MUL2: acc_next = acc_reg + {prod_reg[31:0], 32'd0};
            cwip_pkg::OP_MUL3: v_next = (acc_reg + {prod_reg[31:0], 32'd0}) & cfg.mask;
            cwip_pkg::OP_XS1:  v_next = v_reg ^ (v_reg >> cfg.first_shift);
            cwip_pkg::OP_XS2:  v_next = v_reg ^ (v_reg >> cfg.second_shift);
            default:           v_next = v_reg;
        endcase
        if (ctrl.load_in)
        begin
            v_next = index;
        end
    end

    always_ff @(posedge clk)
    begin
        v_reg   <= v_next;
        acc_reg <= acc_next;
        if (ctrl.load_out)
        begin
            perm_reg <= ctrl.out_rej ? 64'd0 : v_reg;
            rej_reg  <= ctrl.out_rej;
        end
    end

    assign v_ge_size      = v_reg >= cfg.size;
    assign permuted_index = perm_reg;
    assign rejected       = rej_reg;

endmodule

`default_nettype wire

[design/cwip_sequencer.sv]
// Microcode sequencer: step counter, control store lookup, branches and handshakes.
`default_nettype none

module cwip_sequencer (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            in_valid,
    output logic                 in_stall,
    output logic                 out_valid,
    input  wire logic            out_stall,
    input  wire cwip_pkg::status_t status,
    output cwip_pkg::ctrl_t      ctrl
);

    cwip_pkg::seq_state_t           state_reg, state_next;
    logic [cwip_pkg::STEP_W-1:0]    step_reg, step_next;
    logic                           out_valid_reg, out_valid_next;
    cwip_pkg::ucode_t               word;
    logic                           out_free;
    logic                           finish;
    logic                           finish_rej;

    assign word     = cwip_pkg::ucode_word(step_reg);
    assign out_free = !out_valid_reg || !out_stall;
    assign in_stall = (state_reg != cwip_pkg::SEQ_IDLE) || status.cfg_busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= cwip_pkg::SEQ_IDLE;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Next step, branch resolution and control word issue
    always_comb
    begin
        state_next    = state_reg;
        step_next     = step_reg;
        finish        = 1'b0;
        finish_rej    = 1'b0;
        ctrl.op       = cwip_pkg::OP_NOP;
        ctrl.ksel     = word.ksel;
        ctrl.load_in  = 1'b0;
        ctrl.load_out = 1'b0;
        ctrl.out_rej  = 1'b0;
        unique case (state_reg)
            cwip_pkg::SEQ_IDLE:
            begin
                if (in_valid && !in_stall)
                begin
                    ctrl.load_in = 1'b1;
                    step_next    = '0;
                    state_next   = cwip_pkg::SEQ_RUN;
                end
            end
            cwip_pkg::SEQ_RUN:
            begin
                ctrl.op = word.op;
                unique case (word.br)
                    cwip_pkg::BR_NEXT:
                        step_next = step_reg + cwip_pkg::STEP_INC;
                    cwip_pkg::BR_REJECT:
                    begin
                        if (status.v_ge_size)
                        begin
                            finish     = 1'b1;
                            finish_rej = 1'b1;
                        end
                        else
                        begin
                            step_next = step_reg + cwip_pkg::STEP_INC;
                        end
                    end
                    cwip_pkg::BR_LOOP:
                    begin
                        if (status.v_ge_size)
                            step_next = word.target;
                        else
                            finish = 1'b1;
                    end
                    default:
                        step_next = step_reg + cwip_pkg::STEP_INC;
                endcase
                // Deliver to the output register, or hold the step until it frees
                if (finish && out_free)
                begin
                    ctrl.load_out = 1'b1;
                    ctrl.out_rej  = finish_rej;
                    state_next    = cwip_pkg::SEQ_IDLE;
                end
            end
            default:
                state_next = cwip_pkg::SEQ_IDLE;
        endcase
    end

    // Output valid: set on delivery, cleared by a transfer
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_valid_reg && !out_stall)
            out_valid_next = 1'b0;
        if (ctrl.load_out)
            out_valid_next = 1'b1;
    end

    assign out_valid = out_valid_reg;

endmodule

`default_nettype wire

[design/cycle_walking_index_permutation_unit.sv]
// Top level of the cycle-walking index permutation unit.
//
//  channel  | handshake                  | payload
//  ---------+----------------------------+--------------------------------
//  input    | in_valid / in_stall        | index[63:0]
//  output   | out_valid / out_stall      | permuted_index[63:0], rejected
//  config   | domain_size_we             | domain_size[63:0]
//
// One item at a time. A rejected index leaves at the input check, through the
// output register; a walked index runs the input check and then rounds, each
// round being 16 microcode steps around one shared 32x32 multiplier (three
// 64-bit products as three partial products each).
// A domain_size write derives mask and shifts one bit per cycle, with in_stall
// high meanwhile. Reset state is domain_size = 1.
// A stalled output holds the sequencer at its final step; in_stall stays high.
`default_nettype none

module cycle_walking_index_permutation_unit (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        domain_size_we,
    input  wire logic [63:0] domain_size,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [63:0] index,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [63:0]      permuted_index,
    output logic             rejected
);

    cwip_pkg::cfg_t    cfg;
    cwip_pkg::ctrl_t   ctrl;
    cwip_pkg::status_t status;
    logic              cfg_busy;
    logic              v_ge_size;

    cwip_cfg_unit u_cfg (
        .clk            (clk),
        .rst_n          (rst_n),
        .domain_size_we (domain_size_we),
        .domain_size    (domain_size),
        .cfg            (cfg),
        .busy           (cfg_busy)
    );

    cwip_datapath u_dp (
        .clk            (clk),
        .ctrl           (ctrl),
        .cfg            (cfg),
        .index          (index),
        .v_ge_size      (v_ge_size),
        .permuted_index (permuted_index),
        .rejected       (rejected)
    );

    assign status = '{v_ge_size: v_ge_size, cfg_busy: cfg_busy};

    cwip_sequencer u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status),
        .ctrl      (ctrl)
    );

    // A transfer in starts work: no second transfer in the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("input taken while previous item in progress");

    // A size write starts the derivation, which blocks input
    assert property (@(posedge clk) disable iff (!rst_n)
        domain_size_we |=> in_stall)
        else $error("input not blocked during configuration derivation");

    // A rejected result carries a zero index
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && rejected) |-> (permuted_index == 64'd0))
        else $error("rejected result with nonzero index");

endmodule

`default_nettype wire

[bench/cycle_walking_index_permutation_unit_tb.sv]
// Self-checking testbench for the cycle-walking index permutation unit.
module cycle_walking_index_permutation_unit_tb;

    timeunit 1ns;
    timeprecision 1ps;

    // Round constants, kept locally so the predictor stands on its own
    localparam logic [63:0] MIX_OFFSET = 64'h2545f4914f6cdd1d;
    localparam logic [63:0] MIX_MUL_A  = 64'h9e3779b97f4a7c15;
    localparam logic [63:0] MIX_MUL_B  = 64'hbf58476d1ce4e5b9;
    localparam logic [63:0] MIX_MUL_C  = 64'h94d049bb133111eb;

    localparam int CLK_PERIOD  = 12;
    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int TAIL_CYCLES = 100;

    // One expected result
    typedef struct packed {
        logic [63:0] permuted_index;
        logic        rejected;
    } image_t;

    logic        clk;
    logic        rst_n;
    logic        domain_size_we;
    logic [63:0] domain_size;
    logic        in_valid;
    logic        in_stall;
    logic [63:0] index;
    logic        out_valid;
    logic        out_stall;
    logic [63:0] permuted_index;
    logic        rejected;

    // Predictor state, mirrors the block's configuration
    logic [63:0] dom_size;
    logic [63:0] cover_mask;
    logic [5:0]  shift_first;
    logic [5:0]  shift_second;

    image_t expected_images[$];

    int errors;
    int cycle_count;
    int results_seen;
    int rejects_seen;
    int size_writes;
    bit quiet;
    bit in_noisy;

    cycle_walking_index_permutation_unit u_top (
        .clk            (clk),
        .rst_n          (rst_n),
        .domain_size_we (domain_size_we),
        .domain_size    (domain_size),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .index          (index),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .permuted_index (permuted_index),
        .rejected       (rejected)
    );

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // Recompute covering width, mask and shifts for a new domain size
    function automatic void derive_cover(input logic [63:0] size_value);
        int b;
        b = 0;
        while (b < 64 && ((64'd1 << b) < size_value))
            b++;
        dom_size     = size_value;
        cover_mask   = (b >= 64) ? '1 : ((64'd1 << b) - 64'd1);
        shift_first  = (b / 2 < 1) ? 6'd1 : 6'(b / 2);
        shift_second = (b / 3 < 1) ? 6'd1 : 6'(b / 3);
    endfunction

    // One mixing round on the covering range
    function automatic logic [63:0] mix_round(input logic [63:0] v_in);
        logic [63:0] v;
        v = (v_in + MIX_OFFSET) & cover_mask;
        v = (v * MIX_MUL_A) & cover_mask;
        v = v ^ (v >> shift_first);
        v = (v * MIX_MUL_B) & cover_mask;
        v = v ^ (v >> shift_second);
        v = (v * MIX_MUL_C) & cover_mask;
        return v;
    endfunction

    // Image of one index: walk until back inside the domain
    function automatic image_t permute_index(input logic [63:0] idx);
        image_t      r;
        logic [63:0] v;
        r.permuted_index = '0;
        r.rejected       = 1'b1;
        if (idx < dom_size)
        begin
            v = idx;
            do
                v = mix_round(v);
            while (v >= dom_size);
            r.permuted_index = v;
            r.rejected       = 1'b0;
        end
        return r;
    endfunction

    // Index inside the domain when asked and possible, else at or above it
    function automatic logic [63:0] pick_index(input bit in_domain);
        logic [63:0] span;
        if (in_domain && dom_size != 0)
            return rand64() % dom_size;
        if (dom_size == 0)
            return rand64();
        span = ~dom_size + 64'd1;
        if (span == 0)
            return rand64();
        return dom_size + (rand64() % span);
    endfunction

    // Send one index; valid stays high for a following transfer
    task automatic send_index(input logic [63:0] idx);
        int gap;
        if (!quiet && in_noisy && $urandom_range(0, 5) == 0)
        begin
            gap = $urandom_range(1, 5);
            @(negedge clk);
            in_valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        in_valid <= 1'b1;
        index    <= idx;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        expected_images.insert(expected_images.size(), permute_index(idx));
    endtask

    // Drop valid and hold off until every expected result has arrived
    task automatic wait_drained();
        @(negedge clk);
        in_valid <= 1'b0;
        while (expected_images.size() != 0)
            @(posedge clk);
    endtask

    // Write the domain size while the block is idle
    task automatic set_domain_size(input logic [63:0] size_value);
        wait_drained();
        @(negedge clk);
        domain_size_we <= 1'b1;
        domain_size    <= size_value;
        @(posedge clk);
        derive_cover(size_value);
        size_writes++;
        @(negedge clk);
        domain_size_we <= 1'b0;
    endtask

    // Domain size drawn from one of several classes
    function automatic logic [63:0] pick_domain_size();
        int          k;
        logic [63:0] p;
        case ($urandom_range(0, 4))
            0: return 64'($urandom_range(1, 64));
            1:
            begin
                k = $urandom_range(1, 63);
                p = 64'd1 << k;
                return p + 64'($urandom_range(0, 2)) - 64'd1;
            end
            2: return rand64();
            3: return rand64() >> $urandom_range(1, 60);
            default: return ($urandom_range(0, 3) == 0) ? 64'd0 : '1;
        endcase
    endfunction

    // Reset state: domain of one element
    task automatic test_reset_state();
        send_index(64'd0);
        send_index(64'd1);
        send_index('1);
        wait_drained();
    endtask

    // Empty domain: everything is rejected
    task automatic test_zero_domain();
        set_domain_size(64'd0);
        send_index(64'd0);
        send_index('1);
        wait_drained();
    endtask

    // Smallest walking domains, indexes below and at the top
    task automatic test_tiny_domains();
        set_domain_size(64'd2);
        send_index(64'd0);
        send_index(64'd1);
        send_index(64'd2);
        set_domain_size(64'd3);
        send_index(64'd0);
        send_index(64'd1);
        send_index(64'd2);
        wait_drained();
    endtask

    // Wide domains: around 2^32, 2^63 and the full 64-bit range
    task automatic test_wide_domains();
        set_domain_size(64'h0000_0001_0000_0001);
        send_index(64'd0);
        send_index(64'h0000_0001_0000_0000);
        send_index(64'h0000_0001_0000_0001);
        set_domain_size(64'h8000_0000_0000_0000);
        send_index(64'h7fff_ffff_ffff_ffff);
        send_index(64'h8000_0000_0000_0000);
        set_domain_size(64'h8000_0000_0000_0001);
        send_index(64'h8000_0000_0000_0000);
        set_domain_size('1);
        send_index(64'd0);
        send_index(64'hffff_ffff_ffff_fffe);
        send_index('1);
        send_index(64'h5555_5555_5555_5555);
        send_index(64'haaaa_aaaa_aaaa_aaaa);
        wait_drained();
    endtask

    // Random sizes, mostly in-domain indexes, with a mid-phase drain pause
    task automatic test_random_domains(input int phases, input int per_phase);
        for (int p = 0; p < phases; p++)
        begin
            set_domain_size(pick_domain_size());
            for (int i = 0; i < per_phase; i++)
            begin
                if (i % 40 == 0)
                    in_noisy = ($urandom_range(0, 3) != 0);
                if (i == per_phase / 2)
                    wait_drained();
                send_index(pick_index($urandom_range(0, 99) < 85));
            end
        end
        wait_drained();
    endtask

    // Output stall: random bursts, with calm stretches
    initial
    begin : stall_gen
        int stall_left;
        int calm_count;
        bit out_noisy;
        stall_left = 0;
        calm_count = 0;
        out_noisy  = 1'b1;
        out_stall  = 1'b0;
        forever
        begin
            @(negedge clk);
            calm_count++;
            if (calm_count % 300 == 0)
                out_noisy = ($urandom_range(0, 3) != 0);
            if (stall_left == 0 && !quiet && out_noisy && $urandom_range(0, 5) == 0)
                stall_left = $urandom_range(1, 5);
            out_stall <= (stall_left != 0);
            if (stall_left != 0)
                stall_left--;
        end
    end

    // Result checker
    always @(posedge clk)
    begin
        image_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            results_seen++;
            if (rejected)
                rejects_seen++;
            if (expected_images.size() == 0)
            begin
                $error("result with nothing expected: permuted_index %h rejected %b",
                       permuted_index, rejected);
                errors++;
            end
            else
            begin
                want = expected_images.pop_front();
                if (permuted_index !== want.permuted_index)
                begin
                    $error("permuted_index: expected %h, actual %h",
                           want.permuted_index, permuted_index);
                    errors++;
                end
                if (rejected !== want.rejected)
                begin
                    $error("rejected: expected %b, actual %b", want.rejected, rejected);
                    errors++;
                end
            end
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, expected_images.size());
            $display("simulation failed");
            $finish;
        end
    end

    // Test sequence
    initial
    begin
        rst_n          = 1'b0;
        domain_size_we = 1'b0;
        domain_size    = 64'd0;
        in_valid       = 1'b0;
        index          = 64'd0;
        errors         = 0;
        cycle_count    = 0;
        results_seen   = 0;
        rejects_seen   = 0;
        size_writes    = 0;
        quiet          = 1'b0;
        in_noisy       = 1'b1;
        derive_cover(64'd1);

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_reset_state();
        test_zero_domain();
        test_tiny_domains();
        test_wide_domains();
        test_random_domains(12, 150);

        // last part without idling on either side
        quiet = 1'b1;
        test_random_domains(2, 100);

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("covered %0d transfers (%0d rejected, %0d walked) over %0d domain sizes",
                 results_seen, rejects_seen, results_seen - rejects_seen, size_writes);
        $display("sizes from empty to full 64-bit, with random input gaps and output stalls");
        if (errors == 0 && expected_images.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

[sim.f]
design/cwip_pkg.sv
design/cwip_cfg_unit.sv
design/cwip_datapath.sv
design/cwip_sequencer.sv
design/cycle_walking_index_permutation_unit.sv
bench/cycle_walking_index_permutation_unit_tb.sv
